// File: hdl/rse_pkg.sv
// ----------------------------------------------------------------------------
// rse_pkg
// Shared types, register indexes, field codes and GF(2^m) arithmetic for the
// Reed-Solomon encoder.
// ----------------------------------------------------------------------------
package rse_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_FIELD_SELECT = 2'd0;
    localparam logic [1:0] CFG_DATA_COUNT   = 2'd1;
    localparam logic [1:0] CFG_PARITY_COUNT = 2'd2;

    // field codes, equal to the field_select register codes
    localparam logic [1:0] FLD_M3 = 2'd0;
    localparam logic [1:0] FLD_M4 = 2'd1;
    localparam logic [1:0] FLD_M8 = 2'd2;

    typedef logic [1:0] field_t;

    // input item
    typedef struct packed {
        logic [7:0] data_symbol;
    } rse_in_t;

    // result item
    typedef struct packed {
        logic [7:0] code_symbol;
        logic       is_parity;
        logic       block_end;
    } rse_out_t;

    // control from the top level to the remainder bank
    typedef struct packed {
        logic   update;
        logic   shift;
        field_t fld;
    } rse_rem_ctl_t;

    // symbol mask of a field
    function automatic logic [7:0] field_mask(field_t fld);
        logic [7:0] mask;
        case (fld)
            FLD_M3:  mask = 8'h07;
            FLD_M4:  mask = 8'h0F;
            default: mask = 8'hFF;
        endcase
        return mask;
    endfunction

    // shift-and-add multiply, reducing by the field's primitive polynomial
    function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b, field_t fld);
        logic [8:0] aa;
        logic [8:0] poly;
        logic [3:0] m;
        logic [7:0] mask;
        logic [7:0] r;
        case (fld)
            FLD_M3:
            begin
                m    = 4'd3;
                poly = 9'h00B;
            end
            FLD_M4:
            begin
                m    = 4'd4;
                poly = 9'h013;
            end
            default:
            begin
                m    = 4'd8;
                poly = 9'h11D;
            end
        endcase
        mask = field_mask(fld);
        aa   = {1'b0, a & mask};
        r    = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (i < int'(m))
            begin
                if (b[i])
                    r = r ^ aa[7:0];
                aa = aa << 1;
                if (aa[m])
                    aa = aa ^ poly;
            end
        end
        return r & mask;
    endfunction

endpackage

// File: hdl/rse_stream_if.sv
// ----------------------------------------------------------------------------
// rse_stream_if
// Valid/ready stream channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface rse_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: hdl/rse_gen.sv
// ----------------------------------------------------------------------------
// rse_gen
// Generator polynomial builder: multiplies g(x) by (x + alpha^i) once per
// cycle, all coefficients in parallel, restarting after every config write.
// ----------------------------------------------------------------------------
module rse_gen
    import rse_pkg::*;
#(
    parameter int MAX_PARITY   = 32,
    parameter int SYMBOL_WIDTH = 8
)(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             restart,
    input  field_t                           fld,
    input  logic [$clog2(MAX_PARITY+1)-1:0]  parity,
    output logic [SYMBOL_WIDTH-1:0]          coeffs [MAX_PARITY],
    output logic                             done
);
    localparam int PW = $clog2(MAX_PARITY + 1);

    logic                    start_reg,  start_next;
    logic [PW-1:0]           step_reg,   step_next;
    logic [SYMBOL_WIDTH-1:0] root_reg,   root_next;
    logic [SYMBOL_WIDTH-1:0] poly_reg  [MAX_PARITY+1];
    logic [SYMBOL_WIDTH-1:0] poly_next [MAX_PARITY+1];

    // initialisation on (re)start, then one multiply-by-(x + root) step per cycle
    always_comb
    begin
        start_next = start_reg;
        step_next  = step_reg;
        root_next  = root_reg;
        poly_next  = poly_reg;
        if (start_reg)
        begin
            for (int k = 0; k <= MAX_PARITY; k++)
                poly_next[k] = '0;
            poly_next[0] = SYMBOL_WIDTH'(1);
            root_next    = SYMBOL_WIDTH'(1);
            step_next    = '0;
            start_next   = 1'b0;
        end
        else if (step_reg < parity)
        begin
            for (int k = 0; k <= MAX_PARITY; k++)
            begin
                if (k == 0)
                    poly_next[k] = SYMBOL_WIDTH'(gf_mul(8'(poly_reg[k]), 8'(root_reg), fld));
                else
                    poly_next[k] = poly_reg[k-1] ^
                        SYMBOL_WIDTH'(gf_mul(8'(poly_reg[k]), 8'(root_reg), fld));
            end
            root_next = SYMBOL_WIDTH'(gf_mul(8'(root_reg), 8'h02, fld));
            step_next = step_reg + PW'(1);
        end
        if (restart)
            start_next = 1'b1;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= 1'b1;
            step_reg  <= '0;
        end
        else
        begin
            start_reg <= start_next;
            step_reg  <= step_next;
        end
    end

    // coefficient bank
    always_ff @(posedge clk)
    begin
        root_reg <= root_next;
        poly_reg <= poly_next;
    end

    // low-order coefficients; the leading one is always 1
    always_comb
    begin
        for (int k = 0; k < MAX_PARITY; k++)
            coeffs[k] = poly_reg[k];
    end

    assign done = !start_reg && !restart && (step_reg == parity);

endmodule

// File: hdl/rse_rem.sv
// ----------------------------------------------------------------------------
// rse_rem
// Parity remainder bank: one LFSR division step per data symbol, and a
// shift toward the top while parity symbols drain out.
// ----------------------------------------------------------------------------
module rse_rem
    import rse_pkg::*;
#(
    parameter int MAX_PARITY   = 32,
    parameter int SYMBOL_WIDTH = 8
)(
    input  logic                             clk,
    input  logic                             rst_n,
    input  rse_rem_ctl_t                     ctl,
    input  logic [$clog2(MAX_PARITY+1)-1:0]  parity,
    input  logic [SYMBOL_WIDTH-1:0]          data,
    input  logic [SYMBOL_WIDTH-1:0]          coeffs [MAX_PARITY],
    output logic [SYMBOL_WIDTH-1:0]          top
);
    localparam int PW = $clog2(MAX_PARITY + 1);
    localparam int IW = (MAX_PARITY > 1) ? $clog2(MAX_PARITY) : 1;

    logic [SYMBOL_WIDTH-1:0] rem_reg  [MAX_PARITY];
    logic [SYMBOL_WIDTH-1:0] rem_next [MAX_PARITY];
    logic [IW-1:0]           top_idx;
    logic [SYMBOL_WIDTH-1:0] fb;

    // highest-degree remainder symbol of the active code
    assign top_idx = IW'(parity - PW'(1));
    assign top     = (parity == '0) ? '0 : rem_reg[top_idx];
    assign fb      = data ^ top;

    // division step or drain shift, only over the active length
    always_comb
    begin
        rem_next = rem_reg;
        for (int j = 0; j < MAX_PARITY; j++)
        begin
            if (j < int'(parity))
            begin
                if (ctl.update)
                begin
                    if (j == 0)
                        rem_next[j] = SYMBOL_WIDTH'(gf_mul(8'(fb), 8'(coeffs[j]), ctl.fld));
                    else
                        rem_next[j] = rem_reg[j-1] ^
                            SYMBOL_WIDTH'(gf_mul(8'(fb), 8'(coeffs[j]), ctl.fld));
                end
                else if (ctl.shift)
                begin
                    if (j == 0)
                        rem_next[j] = '0;
                    else
                        rem_next[j] = rem_reg[j-1];
                end
            end
        end
    end

    // remainder registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < MAX_PARITY; j++)
                rem_reg[j] <= '0;
        end
        else
        begin
            rem_reg <= rem_next;
        end
    end

endmodule

// File: hdl/reed_solomon_encoder.sv
// ----------------------------------------------------------------------------
// reed_solomon_encoder
// Systematic Reed-Solomon encoder over GF(2^3), GF(2^4) or GF(2^8).
// ----------------------------------------------------------------------------
// Data symbols are taken one per cycle while the code channel is not stalled
// and echoed on the code channel in the next cycle, masked to the field
// width, while the remainder bank updates in the same cycle. After the
// block's last data symbol the input is held off while the parity symbols
// leave one per cycle, unless the code channel stalls, highest degree
// first, the last one flagged with block_end. Field, block length and
// parity count are sampled with the first symbol of a block. The generator
// polynomial is rebuilt after reset and after every configuration write,
// one factor per cycle, and the first symbol of a block is taken only once
// the rebuild is done; symbols inside a running block are never delayed by it.
// ----------------------------------------------------------------------------
module reed_solomon_encoder
    import rse_pkg::*;
#(
    parameter int MAX_PARITY   = 32,
    parameter int SYMBOL_WIDTH = 8
)(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [7:0]   cfg_wdata,
    rse_stream_if.sink   msg,
    rse_stream_if.source code
);
    localparam int PW = $clog2(MAX_PARITY + 1);

    // configuration registers
    logic [1:0]              field_sel_reg;
    logic [7:0]              data_count_reg;
    logic [5:0]              parity_count_reg;

    // per-block settings
    field_t                  blk_fld_reg;
    logic [7:0]              blk_count_reg;
    logic [PW-1:0]           blk_parity_reg;
    logic [SYMBOL_WIDTH-1:0] blk_coef_reg [MAX_PARITY];

    // sequencing and output stage
    logic [7:0]              idx_reg,   idx_next;
    logic [PW-1:0]           drain_reg, drain_next;
    logic                    out_valid_reg, out_valid_next;
    rse_out_t                out_reg,   out_next;

    field_t                  cur_fld;
    logic [PW-1:0]           cur_parity;
    logic [7:0]              cur_count;
    field_t                  act_fld;
    logic [PW-1:0]           act_parity;
    logic [7:0]              act_count;
    logic [SYMBOL_WIDTH-1:0] act_coef [MAX_PARITY];
    logic [SYMBOL_WIDTH-1:0] gen_coef [MAX_PARITY];
    logic                    gen_done;
    logic                    blk_start;
    logic                    out_free;
    logic                    accept;
    logic                    last;
    logic [7:0]              data_masked;
    logic [SYMBOL_WIDTH-1:0] rem_top;
    logic [PW-1:0]           rem_parity;
    rse_rem_ctl_t            rem_ctl;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_sel_reg    <= FLD_M8;
            data_count_reg   <= 8'd223;
            parity_count_reg <= 6'd32;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FIELD_SELECT: field_sel_reg    <= cfg_wdata[1:0];
                CFG_DATA_COUNT:   data_count_reg   <= cfg_wdata;
                CFG_PARITY_COUNT: parity_count_reg <= cfg_wdata[5:0];
                default:          ;
            endcase
        end
    end

    // field choice with fallback to what fits in the symbol width
    always_comb
    begin
        case (field_sel_reg)
            FLD_M3:  cur_fld = FLD_M3;
            FLD_M4:  cur_fld = FLD_M4;
            default: cur_fld = FLD_M8;
        endcase
        if (cur_fld == FLD_M8 && SYMBOL_WIDTH < 8)
            cur_fld = (SYMBOL_WIDTH >= 4) ? FLD_M4 : FLD_M3;
        if (cur_fld == FLD_M4 && SYMBOL_WIDTH < 4)
            cur_fld = FLD_M3;
    end

    // saturated parity count and non-zero block length
    assign cur_parity = (int'(parity_count_reg) > MAX_PARITY) ? PW'(MAX_PARITY)
                                                               : PW'(parity_count_reg);
    assign cur_count  = (data_count_reg == 8'd0) ? 8'd1 : data_count_reg;

    // generator builder
    rse_gen #(
        .MAX_PARITY   (MAX_PARITY),
        .SYMBOL_WIDTH (SYMBOL_WIDTH)
    ) u_gen (
        .clk     (clk),
        .rst_n   (rst_n),
        .restart (cfg_we),
        .fld     (cur_fld),
        .parity  (cur_parity),
        .coeffs  (gen_coef),
        .done    (gen_done)
    );

    // settings in force: fresh ones on the first symbol of a block
    assign blk_start  = (idx_reg == 8'd0);
    assign act_fld    = blk_start ? cur_fld    : blk_fld_reg;
    assign act_parity = blk_start ? cur_parity : blk_parity_reg;
    assign act_count  = blk_start ? cur_count  : blk_count_reg;

    always_comb
    begin
        for (int j = 0; j < MAX_PARITY; j++)
            act_coef[j] = blk_start ? gen_coef[j] : blk_coef_reg[j];
    end

    // handshake
    assign out_free    = !out_valid_reg || code.ready;
    assign msg.ready   = out_free && (drain_reg == '0) && (!blk_start || gen_done);
    assign accept      = msg.valid && msg.ready;
    assign last        = ({1'b0, idx_reg} + 9'd1) >= {1'b0, act_count};
    assign data_masked = msg.payload.data_symbol & field_mask(act_fld);

    // remainder bank
    assign rem_ctl.update = accept;
    assign rem_ctl.shift  = !accept && (drain_reg != '0) && out_free;
    assign rem_ctl.fld    = act_fld;
    assign rem_parity     = (drain_reg != '0) ? blk_parity_reg : act_parity;

    rse_rem #(
        .MAX_PARITY   (MAX_PARITY),
        .SYMBOL_WIDTH (SYMBOL_WIDTH)
    ) u_rem (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (rem_ctl),
        .parity (rem_parity),
        .data   (SYMBOL_WIDTH'(data_masked)),
        .coeffs (act_coef),
        .top    (rem_top)
    );

    // next output and sequencing state
    always_comb
    begin
        idx_next       = idx_reg;
        drain_next     = drain_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (accept)
        begin
            out_next.code_symbol = data_masked;
            out_next.is_parity   = 1'b0;
            out_next.block_end   = last && (act_parity == '0);
            out_valid_next       = 1'b1;
            idx_next             = last ? 8'd0 : idx_reg + 8'd1;
            drain_next           = last ? act_parity : '0;
        end
        else if ((drain_reg != '0) && out_free)
        begin
            out_next.code_symbol = 8'(rem_top);
            out_next.is_parity   = 1'b1;
            out_next.block_end   = (drain_reg == PW'(1));
            out_valid_next       = 1'b1;
            drain_next           = drain_reg - PW'(1);
        end
        else if (code.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 8'd0;
            drain_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            drain_reg     <= drain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload and block settings
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (accept && blk_start)
        begin
            blk_fld_reg    <= cur_fld;
            blk_count_reg  <= cur_count;
            blk_parity_reg <= cur_parity;
            blk_coef_reg   <= gen_coef;
        end
    end

    assign code.valid   = out_valid_reg;
    assign code.payload = out_reg;

endmodule

// File: hdl/rse_checker.sv
// ----------------------------------------------------------------------------
// rse_checker
// Port-level checks of the encoder's transfer sequencing, bound to the top.
// ----------------------------------------------------------------------------
module rse_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       msg_valid,
    input logic       msg_ready,
    input logic       code_valid,
    input logic       code_ready,
    input logic [7:0] code_symbol,
    input logic       is_parity,
    input logic       block_end
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        code_valid && !code_ready |=> code_valid && $stable(code_symbol) &&
            $stable(is_parity) && $stable(block_end))
        else $error("result changed while stalled");

    // every input transfer is echoed as a data symbol next cycle
    a_echo: assert property (@(posedge clk) disable iff (!rst_n)
        msg_valid && msg_ready |=> code_valid && !is_parity)
        else $error("data symbol not echoed");

    // no input while a parity symbol other than the block's last is on the output
    a_no_input_mid_parity: assert property (@(posedge clk) disable iff (!rst_n)
        code_valid && is_parity && !block_end |-> !(msg_valid && msg_ready))
        else $error("input taken during parity drain");

    // parity symbols follow each other without gaps
    a_parity_run: assert property (@(posedge clk) disable iff (!rst_n)
        code_valid && code_ready && is_parity && !block_end |=> code_valid && is_parity)
        else $error("parity run broken");

endmodule

bind reed_solomon_encoder rse_checker u_rse_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .msg_valid   (msg.valid),
    .msg_ready   (msg.ready),
    .code_valid  (code.valid),
    .code_ready  (code.ready),
    .code_symbol (code.payload.code_symbol),
    .is_parity   (code.payload.is_parity),
    .block_end   (code.payload.block_end)
);
